>>> hw/rtl/ahr_pkg.sv
// Shared types and constants for the accelerating hold-repeat block.
// No dependencies; every other file imports this package.
package ahr_pkg;

  localparam int TIME_W = 32;
  localparam int REG_W  = 16;
  localparam int IDX_W  = 3;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [REG_W-1:0]  reg_val_t;
  typedef logic signed [1:0] dir_t;

  typedef enum logic [IDX_W-1:0] {
    REG_INITIAL_DELAY = 3'd0,
    REG_MID_TIER_AFTER = 3'd1,
    REG_FAST_TIER_AFTER = 3'd2,
    REG_SLOW_INTERVAL = 3'd3,
    REG_MID_INTERVAL = 3'd4,
    REG_FAST_INTERVAL = 3'd5
  } reg_idx_t;

  typedef struct packed {
    reg_val_t initial_delay_ms;
    reg_val_t mid_tier_after_ms;
    reg_val_t fast_tier_after_ms;
    reg_val_t slow_interval_ms;
    reg_val_t mid_interval_ms;
    reg_val_t fast_interval_ms;
  } cfg_t;

  localparam reg_val_t RST_INITIAL_DELAY   = 16'd500;
  localparam reg_val_t RST_MID_TIER_AFTER  = 16'd1200;
  localparam reg_val_t RST_FAST_TIER_AFTER = 16'd2500;
  localparam reg_val_t RST_SLOW_INTERVAL   = 16'd120;
  localparam reg_val_t RST_MID_INTERVAL    = 16'd60;
  localparam reg_val_t RST_FAST_INTERVAL   = 16'd25;

  localparam dir_t DIR_NONE = 2'sd0;

endpackage

>>> hw/rtl/ahr_if.sv
// Valid/ready channel interfaces for input items and fire results.
// Depends on ahr_pkg for payload types.
interface ahr_item_if import ahr_pkg::*; ();
  logic  valid;
  logic  ready;
  dir_t  direction;
  time_t now_ms;

  modport source (output valid, output direction, output now_ms, input ready);
  modport sink (input valid, input direction, input now_ms, output ready);
endinterface

interface ahr_result_if;
  logic valid;
  logic ready;
  logic fire;

  modport source (output valid, output fire, input ready);
  modport sink (input valid, input fire, output ready);
endinterface

>>> hw/rtl/accelerating_hold_repeat.sv
// Accelerating hold-repeat: typematic auto-repeat with three rate tiers.
// Each accepted item passes the input register and then the result register.
// Throughput: one item per cycle while result.ready is high; the input register, decision
// logic and result register form one pass; state updates in the same cycle as the decision.
// Reset clears the pipeline and held state and loads the default timing registers.
module accelerating_hold_repeat
  import ahr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  ahr_item_if.sink           item,
  ahr_result_if.source       result,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  reg_val_t           cfg_data
);

  cfg_t  cfg;
  logic  in_valid;
  dir_t  in_dir;
  time_t in_now;
  logic  out_valid;
  logic  out_fire;
  logic  core_fire;
  logic  advance;

  ahr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ahr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .direction (in_dir),
    .now_ms    (in_now),
    .cfg       (cfg),
    .fire      (core_fire)
  );

  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_dir <= item.direction;
      in_now <= item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_fire <= core_fire;
    end
  end

  assign result.valid = out_valid;
  assign result.fire  = out_fire;

endmodule

>>> hw/rtl/ahr_cfg_regs.sv
// Configuration register file for the hold-repeat timing.
// Depends on ahr_pkg for the register index codes and cfg_t.
module ahr_cfg_regs
  import ahr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  reg_val_t         cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_delay_ms   <= RST_INITIAL_DELAY;
      cfg.mid_tier_after_ms  <= RST_MID_TIER_AFTER;
      cfg.fast_tier_after_ms <= RST_FAST_TIER_AFTER;
      cfg.slow_interval_ms   <= RST_SLOW_INTERVAL;
      cfg.mid_interval_ms    <= RST_MID_INTERVAL;
      cfg.fast_interval_ms   <= RST_FAST_INTERVAL;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_INITIAL_DELAY:   cfg.initial_delay_ms   <= cfg_data;
        REG_MID_TIER_AFTER:  cfg.mid_tier_after_ms  <= cfg_data;
        REG_FAST_TIER_AFTER: cfg.fast_tier_after_ms <= cfg_data;
        REG_SLOW_INTERVAL:   cfg.slow_interval_ms   <= cfg_data;
        REG_MID_INTERVAL:    cfg.mid_interval_ms    <= cfg_data;
        REG_FAST_INTERVAL:   cfg.fast_interval_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/ahr_core.sv
// Hold-repeat decision logic and its state: held direction, hold start, last fire.
// Depends on ahr_pkg for cfg_t and the time and direction types.
module ahr_core
  import ahr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  dir_t  direction,
  input  time_t now_ms,
  input  cfg_t  cfg,
  output logic  fire
);

  dir_t  held_dir;
  dir_t  held_dir_next;
  time_t hold_start;
  time_t hold_start_next;
  time_t last_fire;
  time_t last_fire_next;

  time_t    held;
  time_t    since;
  reg_val_t interval;
  logic     past_delay;
  logic     due;

  always_comb begin
    held  = now_ms - hold_start;
    since = now_ms - last_fire;
    past_delay = held > time_t'(cfg.initial_delay_ms);
    if (held > time_t'(cfg.fast_tier_after_ms)) begin
      interval = cfg.fast_interval_ms;
    end else if (held > time_t'(cfg.mid_tier_after_ms)) begin
      interval = cfg.mid_interval_ms;
    end else begin
      interval = cfg.slow_interval_ms;
    end
    due = since >= time_t'(interval);

    held_dir_next   = held_dir;
    hold_start_next = hold_start;
    last_fire_next  = last_fire;
    fire            = 1'b0;
    if (direction == DIR_NONE) begin
      held_dir_next = DIR_NONE;
    end else if (direction != held_dir) begin
      held_dir_next   = direction;
      hold_start_next = now_ms;
      last_fire_next  = now_ms;
      fire            = 1'b1;
    end else if (past_delay && due) begin
      last_fire_next = now_ms;
      fire           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_dir   <= DIR_NONE;
      hold_start <= '0;
      last_fire  <= '0;
    end else if (step) begin
      held_dir   <= held_dir_next;
      hold_start <= hold_start_next;
      last_fire  <= last_fire_next;
    end
  end

endmodule

>>> tb/sv/tb.sv
// Testbench for accelerating_hold_repeat: drives held-direction words with millisecond
// stamps through several timing settings and checks every fire word in order.
// Depends on ahr_pkg, the ahr_item_if/ahr_result_if interfaces and the block itself.
module tb;
  import ahr_pkg::*;

  localparam int RESET_CYCLES     = 8;
  localparam int RANDOM_WORDS     = 148;
  localparam int PHASES           = 9;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int DRAIN_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int SHOWN_MISMATCHES = 10;

  localparam dir_t DIR_UP    = 2'sb01;
  localparam dir_t DIR_DOWN  = 2'sb11;
  localparam dir_t DIR_SPARE = 2'sb10;

  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  localparam cfg_t RESET_TIMING = '{RST_INITIAL_DELAY, RST_MID_TIER_AFTER,
                                    RST_FAST_TIER_AFTER, RST_SLOW_INTERVAL,
                                    RST_MID_INTERVAL, RST_FAST_INTERVAL};

  typedef struct packed {
    dir_t  dir;
    time_t stamp;
    logic  typed;
    logic  fire;
  } probe_t;

  localparam int OPENING_ROWS = 26;
  localparam probe_t OPENING [OPENING_ROWS] = '{
    '{DIR_NONE,  32'h0000_0000, 1'b1, 1'b0},
    '{DIR_UP,    32'd100,       1'b1, 1'b1},
    '{DIR_UP,    32'd600,       1'b1, 1'b0},
    '{DIR_UP,    32'd601,       1'b1, 1'b1},
    '{DIR_UP,    32'd700,       1'b0, 1'b0},
    '{DIR_UP,    32'd721,       1'b0, 1'b0},
    '{DIR_DOWN,  32'd800,       1'b1, 1'b1},
    '{DIR_SPARE, 32'd801,       1'b1, 1'b1},
    '{DIR_SPARE, 32'd1302,      1'b0, 1'b0},
    '{DIR_NONE,  32'd1303,      1'b1, 1'b0},
    '{DIR_SPARE, 32'd1304,      1'b1, 1'b1},
    '{DIR_UP,    32'hFFFF_FF00, 1'b1, 1'b1},
    '{DIR_UP,    32'h0000_0200, 1'b0, 1'b0},
    '{DIR_UP,    32'h0000_0278, 1'b0, 1'b0},
    '{DIR_UP,    32'h0000_0700, 1'b0, 1'b0},
    '{DIR_UP,    32'h0000_073B, 1'b0, 1'b0},
    '{DIR_UP,    32'h0000_073C, 1'b0, 1'b0},
    '{DIR_UP,    32'h0000_0A00, 1'b0, 1'b0},
    '{DIR_UP,    32'h0000_0A18, 1'b0, 1'b0},
    '{DIR_UP,    32'h0000_0A19, 1'b0, 1'b0},
    '{DIR_UP,    32'h0000_0A19, 1'b0, 1'b0},
    '{DIR_DOWN,  32'hFFFF_FFFF, 1'b1, 1'b1},
    '{DIR_NONE,  32'hFFFF_FFFF, 1'b1, 1'b0},
    '{DIR_NONE,  32'h0000_0000, 1'b1, 1'b0},
    '{DIR_DOWN,  32'h5555_AAAA, 1'b1, 1'b1},
    '{DIR_DOWN,  32'hAAAA_5555, 1'b0, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [IDX_W-1:0]     cfg_index;
  reg_val_t             cfg_data;

  ahr_item_if   item_ch ();
  ahr_result_if result_ch ();

  accelerating_hold_repeat i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cfg_t  timing;
  dir_t  hold_dir;
  time_t hold_origin;
  time_t last_step;

  bit pending_fires[$];
  int words_sent;
  int fires_checked;
  int fires_seen;
  int faults;
  int settings_run;
  int stall_cycles;
  bit idle_on;
  bit squeeze;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit advance_hold(input dir_t d, input time_t stamp);
    time_t held;
    time_t since;
    time_t spacing;
    if (d == DIR_NONE) begin
      hold_dir = DIR_NONE;
      return 1'b0;
    end
    if (d != hold_dir) begin
      hold_dir    = d;
      hold_origin = stamp;
      last_step   = stamp;
      return 1'b1;
    end
    held = stamp - hold_origin;
    if (held <= time_t'(timing.initial_delay_ms)) return 1'b0;
    since = stamp - last_step;
    // fast tier wins where both thresholds are passed
    if (held > time_t'(timing.fast_tier_after_ms)) begin
      spacing = time_t'(timing.fast_interval_ms);
    end else if (held > time_t'(timing.mid_tier_after_ms)) begin
      spacing = time_t'(timing.mid_interval_ms);
    end else begin
      spacing = time_t'(timing.slow_interval_ms);
    end
    if (since < spacing) return 1'b0;
    last_step = stamp;
    return 1'b1;
  endfunction

  task automatic write_timing(input logic [IDX_W-1:0] idx, input reg_val_t value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_INITIAL_DELAY:   timing.initial_delay_ms   = value;
      REG_MID_TIER_AFTER:  timing.mid_tier_after_ms  = value;
      REG_FAST_TIER_AFTER: timing.fast_tier_after_ms = value;
      REG_SLOW_INTERVAL:   timing.slow_interval_ms   = value;
      REG_MID_INTERVAL:    timing.mid_interval_ms    = value;
      REG_FAST_INTERVAL:   timing.fast_interval_ms   = value;
      default: ;
    endcase
  endtask

  task automatic load_timing(input cfg_t v);
    write_timing(REG_INITIAL_DELAY, v.initial_delay_ms);
    write_timing(REG_MID_TIER_AFTER, v.mid_tier_after_ms);
    write_timing(REG_FAST_TIER_AFTER, v.fast_tier_after_ms);
    write_timing(REG_SLOW_INTERVAL, v.slow_interval_ms);
    write_timing(REG_MID_INTERVAL, v.mid_interval_ms);
    write_timing(REG_FAST_INTERVAL, v.fast_interval_ms);
    // unmapped index: must leave every register alone
    write_timing($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI, reg_val_t'($urandom));
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  task automatic send_word(input dir_t d, input time_t stamp, input bit typed,
                           input bit typed_fire);
    bit model_fire;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.direction <= d;
    item_ch.now_ms    <= stamp;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    model_fire = advance_hold(d, stamp);
    pending_fires.push_back(typed ? typed_fire : model_fire);
    words_sent++;
  endtask

  task automatic quiesce();
    item_ch.valid <= 1'b0;
    while (pending_fires.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input time_t base);
    time_t stamp;
    dir_t  d;
    int    step_max;
    int    span;
    int    left;
    int    hold_len;
    stamp    = base;
    step_max = int'(timing.slow_interval_ms);
    if (int'(timing.mid_interval_ms) > step_max) step_max = int'(timing.mid_interval_ms);
    if (int'(timing.fast_interval_ms) > step_max) step_max = int'(timing.fast_interval_ms);
    step_max = step_max / 2 + 1;
    if (int'(timing.fast_tier_after_ms) / 40 + 1 > step_max) begin
      step_max = int'(timing.fast_tier_after_ms) / 40 + 1;
    end
    left = RANDOM_WORDS;
    while (left > 0) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise: any code at any time
        stamp = $urandom;
        d     = dir_t'($urandom_range(0, 3));
        send_word(d, stamp, 1'b0, 1'b0);
        left--;
      end else begin
        case ($urandom_range(0, 3))
          0:       d = DIR_SPARE;
          1:       d = DIR_DOWN;
          default: d = DIR_UP;
        endcase
        hold_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 160)
                                               : $urandom_range(1, 40);
        while (hold_len > 0 && left > 0) begin
          span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4 * step_max)
                                             : $urandom_range(0, step_max);
          stamp = stamp + span;
          send_word(d, stamp, 1'b0, 1'b0);
          hold_len--;
          left--;
        end
        if (left > 0 && $urandom_range(0, 2) != 0) begin
          stamp = stamp + $urandom_range(0, step_max);
          send_word(DIR_NONE, stamp, 1'b0, 1'b0);
          left--;
        end
      end
    end
  endtask

  initial begin
    cfg_t  next_timing;
    time_t base;
    rst               <= 1'b1;
    cfg_write         <= 1'b0;
    cfg_index         <= REG_INITIAL_DELAY;
    cfg_data          <= '0;
    item_ch.valid     <= 1'b0;
    item_ch.direction <= DIR_NONE;
    item_ch.now_ms    <= '0;
    idle_on      = 1'b1;
    squeeze      = 1'b0;
    timing       = RESET_TIMING;
    hold_dir     = DIR_NONE;
    hold_origin  = '0;
    last_step    = '0;
    settings_run = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < OPENING_ROWS; i++) begin
      send_word(OPENING[i].dir, OPENING[i].stamp, OPENING[i].typed, OPENING[i].fire);
    end
    run_random(OPENING[OPENING_ROWS-1].stamp);

    for (int p = 1; p < PHASES; p++) begin
      quiesce();
      case (p)
        1: next_timing = '0;
        2: next_timing = '1;
        3: next_timing = '{16'd100, 16'd3000, 16'd800, 16'd90, 16'd40, 16'd10};
        4: next_timing = '{16'd50, 16'd300, 16'd600, 16'd0, 16'd0, 16'd0};
        5, 7: begin
          next_timing.initial_delay_ms   = reg_val_t'($urandom_range(0, 400));
          next_timing.mid_tier_after_ms  = reg_val_t'($urandom_range(0, 400));
          next_timing.fast_tier_after_ms = reg_val_t'($urandom_range(0, 400));
          next_timing.slow_interval_ms   = reg_val_t'($urandom_range(0, 400));
          next_timing.mid_interval_ms    = reg_val_t'($urandom_range(0, 400));
          next_timing.fast_interval_ms   = reg_val_t'($urandom_range(0, 400));
        end
        6: next_timing = {$urandom, $urandom, $urandom};
        default: next_timing = RESET_TIMING;
      endcase
      load_timing(next_timing);
      if (p == 3) squeeze = 1'b1;
      if (p == PHASES - 1) idle_on = 1'b0;
      base = (p % 3 == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;
      run_random(base);
    end
    quiesce();

    $display("Sent %0d words, checked %0d fire words (%0d fired), %0d timing settings.",
             words_sent, fires_checked, fires_seen, settings_run);
    $display("Settings spanned reset values, all-zero, full-scale, inverted tiers, "
             , "zero intervals and random timing, with time wrap.");
    if (faults == 0 && pending_fires.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    result_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (squeeze) begin
        // hold off long enough for the block to back up into its input
        result_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
        squeeze = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_fire
    bit want;
    if (!rst) begin
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_fires.size() == 0) begin
          faults++;
          if (faults <= SHOWN_MISMATCHES) begin
            $display("unexpected fire word %0b with nothing pending", result_ch.fire);
          end
        end else begin
          want = pending_fires.pop_front();
          if (result_ch.fire) fires_seen++;
          if (result_ch.fire !== want) begin
            faults++;
            if (faults <= SHOWN_MISMATCHES) begin
              $display("fire word %0d: expected %0b, got %0b", fires_checked, want,
                       result_ch.fire);
            end
          end
          fires_checked++;
        end
      end
    end
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("no handshake for %0d cycles, %0d fire words pending", stall_cycles,
             pending_fires.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ahr_pkg.sv
hw/rtl/ahr_if.sv
hw/rtl/ahr_cfg_regs.sv
hw/rtl/ahr_core.sv
hw/rtl/accelerating_hold_repeat.sv
tb/sv/tb.sv
